### rtl/core/c3x3_pkg.sv
// c3x3_pkg: shared types and constants of the 3x3 multichannel convolution
// used by c3x3_mac and conv3x3_same_pad_multichannel; no dependencies
`default_nettype none

package c3x3_pkg;

  // kernel geometry
  localparam int KDIM  = 3;
  localparam int KTAPS = KDIM * KDIM;

  // request types on the input channel
  localparam logic [1:0] REQ_COEF   = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_PAD    = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_WIDTH    = 3'd0;
  localparam logic [2:0] CFG_HEIGHT   = 3'd1;
  localparam logic [2:0] CFG_CHANNELS = 3'd2;
  localparam logic [2:0] CFG_SHIFT    = 3'd3;
  localparam logic [2:0] CFG_BIAS     = 3'd4;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_EMIT0,
    S_EMIT1
  } c3x3_state_e;

  // tap control that travels with the operands into the mac
  typedef struct packed {
    logic vld;
    logic use_tap;
    logic win;
  } c3x3_tap_t;

endpackage

`default_nettype wire

### rtl/core/conv3x3_same_pad_multichannel.sv
// conv3x3_same_pad_multichannel: 3x3 same-padded convolution over channels
// depends on c3x3_pkg and c3x3_mac
//
// Usage: load coefficients with req_type 0 (slot channel*9+row*3+col), then
// send samples (req_type 1) in raster order with all channels of a pixel
// back to back, then one row of width*channels flush items (req_type 2).
// Input and result channels use valid/stall; a transfer happens when valid
// is high and stall is low. Configuration writes use cfg_valid_i/cfg_ready_o
// and those to a known index restart the frame; coefficients are kept.
// A coefficient load, a sample in the first row or a sample at column zero
// runs no taps. Other samples run their taps one per cycle through a single
// shared multiplier: 9 taps, or 18 taps at the last column of a row, then a
// drain of the pipeline. On the last channel of a pixel that ran taps one or two
// results follow, one per cycle into the output register while it is not stalled.
// A stalled result holds in the output register; the next input is taken
// once the sequencer has handed over its last result.
// Reset clears positions, sums, state and configuration to their defaults; the
// coefficient and line memories hold garbage until written.
`default_nettype none

module conv3x3_same_pad_multichannel #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 1024,
  parameter int MAX_CHANNELS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  // input items
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [7:0]         coef_index_i,
  input  wire logic signed [15:0] data_value_i,
  // results
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      out_value_o,
  output logic [9:0]              out_row_o,
  output logic [7:0]              out_col_o,
  output logic                    last_in_run_o,
  output logic                    frame_end_o
);

  localparam int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int RW         = $clog2(MAX_HEIGHT + 1);
  localparam int CHW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NW         = $clog2(MAX_CHANNELS + 1);
  localparam int PLANE      = MAX_WIDTH * MAX_CHANNELS;
  localparam int LINE_DEPTH = 3 * PLANE;
  localparam int LAW        = $clog2(LINE_DEPTH);
  localparam int COEF_DEPTH = c3x3_pkg::KTAPS * MAX_CHANNELS;
  localparam int CAW        = $clog2(COEF_DEPTH);

  // configuration registers
  logic [8:0]  width_q;
  logic [10:0] height_q;
  logic [4:0]  chans_q;
  logic [4:0]  shift_q;
  logic [31:0] bias_q;

  // stream position
  logic [RW-1:0]  row_q;
  logic [CW-1:0]  col_q;
  logic [CHW-1:0] ch_q;
  logic [1:0]     rm_q;

  // item being worked on
  logic [RW-1:0]  it_r_q;
  logic [CW-1:0]  it_c_q;
  logic [CHW-1:0] it_ch_q;
  logic [1:0]     it_rm_q;
  logic           it_rowend_q;
  logic           it_emit_q;

  // tap sequencer
  c3x3_pkg::c3x3_state_e state_q, state_d;
  logic       win_q;
  logic [1:0] dr_q, dc_q;
  logic       drain_q;
  logic       tap_last;

  // memories
  logic signed [15:0] coef_mem [COEF_DEPTH];
  logic signed [15:0] line_mem [LINE_DEPTH];
  logic signed [15:0] coef_rd_q;
  logic signed [15:0] line_rd_q;
  logic [CAW-1:0]     coef_ra;
  logic [LAW-1:0]     line_ra;
  logic [LAW-1:0]     line_wa;

  c3x3_pkg::c3x3_tap_t tap_d, tap_q;

  logic [WW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [NW-1:0] n_eff;

  logic in_xfer, cfg_xfer, cfg_hit, out_xfer;
  logic is_coef, is_pix;
  logic last_ch, rowend_now, run_now;
  logic issue, load0, load1, acc_clr;

  logic [31:0] acc0, acc1;

  // output register
  logic               out_valid_q;
  logic signed [15:0] out_value_q;
  logic [9:0]         out_row_q;
  logic [7:0]         out_col_q;
  logic               out_last_q;
  logic               out_fend_q;

  logic signed [15:0] out_value_d_w;
  logic [RW+9:0]      row_ext;
  logic [CW+8:0]      col_ext;

  // effective geometry, saturated to the supported ranges
  always_comb begin
    if (32'(width_q) < 32'd3) begin
      w_eff = WW'(3);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (32'(height_q) < 32'd3) begin
      h_eff = RW'(3);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(height_q);
    end
    if (chans_q == 5'd0) begin
      n_eff = NW'(1);
    end else if (32'(chans_q) > 32'(MAX_CHANNELS)) begin
      n_eff = NW'(MAX_CHANNELS);
    end else begin
      n_eff = NW'(chans_q);
    end
  end

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign cfg_xfer = cfg_valid_i && cfg_ready_o;
  assign cfg_hit  = cfg_xfer && (cfg_index_i == c3x3_pkg::CFG_WIDTH
                    || cfg_index_i == c3x3_pkg::CFG_HEIGHT
                    || cfg_index_i == c3x3_pkg::CFG_CHANNELS
                    || cfg_index_i == c3x3_pkg::CFG_SHIFT
                    || cfg_index_i == c3x3_pkg::CFG_BIAS);
  assign out_xfer = out_valid_q && !out_stall_i;
  assign is_coef  = in_xfer && (req_type_i == c3x3_pkg::REQ_COEF);
  assign is_pix   = in_xfer && (req_type_i == c3x3_pkg::REQ_SAMPLE
                    || req_type_i == c3x3_pkg::REQ_PAD);

  assign last_ch    = (NW'(ch_q) + NW'(1)) == n_eff;
  assign rowend_now = (WW'(col_q) + WW'(1)) == w_eff;
  assign run_now    = (row_q != '0) && ((col_q != '0) || rowend_now);
  assign acc_clr    = is_pix && (row_q != '0) && (ch_q == '0);

  // configuration registers, any known index restarts the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 11'd256;
      chans_q  <= 5'd1;
      shift_q  <= 5'd0;
      bias_q   <= 32'd0;
    end else if (cfg_xfer) begin
      case (cfg_index_i)
        c3x3_pkg::CFG_WIDTH:    width_q  <= cfg_data_i[8:0];
        c3x3_pkg::CFG_HEIGHT:   height_q <= cfg_data_i[10:0];
        c3x3_pkg::CFG_CHANNELS: chans_q  <= cfg_data_i[4:0];
        c3x3_pkg::CFG_SHIFT:    shift_q  <= cfg_data_i[4:0];
        c3x3_pkg::CFG_BIAS:     bias_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // position counters and item capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      ch_q  <= '0;
      rm_q  <= 2'd0;
    end else if (cfg_hit) begin
      row_q <= '0;
      col_q <= '0;
      ch_q  <= '0;
      rm_q  <= 2'd0;
    end else if (is_pix) begin
      if (last_ch) begin
        ch_q <= '0;
        if (rowend_now) begin
          col_q <= '0;
          if (row_q == h_eff) begin
            row_q <= '0;
            rm_q  <= 2'd0;
          end else begin
            row_q <= row_q + RW'(1);
            rm_q  <= (rm_q == 2'd2) ? 2'd0 : rm_q + 2'd1;
          end
        end else begin
          col_q <= col_q + CW'(1);
        end
      end else begin
        ch_q <= ch_q + CHW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_pix) begin
      it_r_q      <= row_q;
      it_c_q      <= col_q;
      it_ch_q     <= ch_q;
      it_rm_q     <= rm_q;
      it_rowend_q <= rowend_now;
      it_emit_q   <= last_ch;
    end
  end

  // memory writes at the input transfer
  assign line_wa = LAW'(32'(rm_q) * PLANE + 32'(col_q) * MAX_CHANNELS + 32'(ch_q));

  always_ff @(posedge clk_i) begin
    if (is_coef && (32'(coef_index_i) < 32'(COEF_DEPTH))) begin
      coef_mem[CAW'(coef_index_i)] <= data_value_i;
    end
    if (is_pix && (row_q != h_eff)) begin
      line_mem[line_wa] <= (req_type_i == c3x3_pkg::REQ_SAMPLE) ? data_value_i : 16'sd0;
    end
  end

  // tap address generation
  always_comb begin
    logic [CW+1:0] pe;
    logic [RW:0]   rs;
    logic [2:0]    slot;
    pe   = (CW+2)'(it_c_q) + (CW+2)'(win_q) + (CW+2)'(dc_q);
    rs   = (RW+1)'(it_r_q) + (RW+1)'(dr_q);
    slot = 3'(it_rm_q) + 3'd1 + 3'(dr_q);
    if (slot >= 3'd3) begin
      slot = slot - 3'd3;
    end
    line_ra = LAW'(32'(slot) * PLANE + 32'(pe - (CW+2)'(2)) * MAX_CHANNELS
                   + 32'(it_ch_q));
    coef_ra = CAW'(32'(it_ch_q) * c3x3_pkg::KTAPS + 32'(dr_q) * c3x3_pkg::KDIM
                   + 32'(dc_q));
    tap_d.vld     = issue;
    tap_d.win     = win_q;
    tap_d.use_tap = issue && (pe >= (CW+2)'(2)) && (pe < (CW+2)'(w_eff) + (CW+2)'(2))
                    && (rs >= (RW+1)'(2)) && (rs < (RW+1)'(h_eff) + (RW+1)'(2));
  end

  // registered memory reads
  always_ff @(posedge clk_i) begin
    line_rd_q <= line_mem[line_ra];
    coef_rd_q <= coef_mem[coef_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else begin
      tap_q <= tap_d;
    end
  end

  c3x3_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (acc_clr),
    .tap_i  (tap_q),
    .line_i (line_rd_q),
    .coef_i (coef_rd_q),
    .acc0_o (acc0),
    .acc1_o (acc1)
  );

  assign tap_last = (dr_q == 2'd2) && (dc_q == 2'd2);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      c3x3_pkg::S_IDLE: begin
        if (is_pix && run_now) begin
          state_d = c3x3_pkg::S_RUN;
        end
      end
      c3x3_pkg::S_RUN: begin
        if (tap_last && (win_q || !it_rowend_q)) begin
          state_d = c3x3_pkg::S_DRAIN;
        end
      end
      c3x3_pkg::S_DRAIN: begin
        if (drain_q) begin
          if (!it_emit_q) begin
            state_d = c3x3_pkg::S_IDLE;
          end else if (it_c_q != '0) begin
            state_d = c3x3_pkg::S_EMIT0;
          end else begin
            state_d = c3x3_pkg::S_EMIT1;
          end
        end
      end
      c3x3_pkg::S_EMIT0: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = it_rowend_q ? c3x3_pkg::S_EMIT1 : c3x3_pkg::S_IDLE;
        end
      end
      c3x3_pkg::S_EMIT1: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = c3x3_pkg::S_IDLE;
        end
      end
      default: state_d = c3x3_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    issue       = 1'b0;
    load0       = 1'b0;
    load1       = 1'b0;
    case (state_q)
      c3x3_pkg::S_IDLE: begin
        in_stall_o  = 1'b0;
        cfg_ready_o = 1'b1;
      end
      c3x3_pkg::S_RUN:   issue = 1'b1;
      c3x3_pkg::S_DRAIN: ;
      c3x3_pkg::S_EMIT0: load0 = !out_valid_q || !out_stall_i;
      c3x3_pkg::S_EMIT1: load1 = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // sequencer registers and tap counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= c3x3_pkg::S_IDLE;
      win_q   <= 1'b0;
      dr_q    <= 2'd0;
      dc_q    <= 2'd0;
      drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (is_pix) begin
        win_q <= (col_q == '0);
        dr_q  <= 2'd0;
        dc_q  <= 2'd0;
      end else if (issue) begin
        if (dc_q == 2'd2) begin
          dc_q <= 2'd0;
          if (dr_q == 2'd2) begin
            dr_q  <= 2'd0;
            win_q <= 1'b1;
          end else begin
            dr_q <= dr_q + 2'd1;
          end
        end else begin
          dc_q <= dc_q + 2'd1;
        end
      end
      // the drain covers the product and accumulate stages
      if (state_q == c3x3_pkg::S_DRAIN) begin
        drain_q <= 1'b1;
      end else begin
        drain_q <= 1'b0;
      end
    end
  end

  // result formatting
  always_comb begin
    logic [31:0]        sum;
    logic signed [31:0] biased;
    logic signed [31:0] shifted;
    sum     = load1 ? acc1 : acc0;
    biased  = $signed(sum + bias_q);
    shifted = biased >>> shift_q;
    out_value_d_w = shifted[15:0];
  end

  assign row_ext = (RW+10)'(it_r_q - RW'(1));
  assign col_ext = load1 ? (CW+9)'(it_c_q) : (CW+9)'(it_c_q - CW'(1));

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load0 || load1) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load0 || load1) begin
      out_value_q <= out_value_d_w;
      out_row_q   <= row_ext[9:0];
      out_col_q   <= col_ext[7:0];
      out_last_q  <= load1 || !it_rowend_q;
      out_fend_q  <= load1 && (it_r_q == h_eff);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign last_in_run_o = out_last_q;
  assign frame_end_o   = out_fend_q;

  // checks
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(col_q) < w_eff) else $error("column position beyond width");

  a_ch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    NW'(ch_q) < n_eff) else $error("channel position beyond channel count");

  a_fend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> last_in_run_o)
    else $error("frame end without end of run");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == c3x3_pkg::S_RUN) |-> in_stall_o && !cfg_ready_o)
    else $error("input taken while taps run");

endmodule

`default_nettype wire

### rtl/core/c3x3_mac.sv
// c3x3_mac: shared 16x16 multiply and two 32-bit wrapping accumulators
// depends on c3x3_pkg for the tap control struct
`default_nettype none

module c3x3_mac (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                clr_i,
  input  wire c3x3_pkg::c3x3_tap_t tap_i,
  input  wire logic signed [15:0]  line_i,
  input  wire logic signed [15:0]  coef_i,
  output logic [31:0]              acc0_o,
  output logic [31:0]              acc1_o
);

  logic signed [31:0] prod_q;
  logic               prod_vld_q;
  logic               prod_win_q;
  logic [31:0]        acc0_q, acc0_d;
  logic [31:0]        acc1_q, acc1_d;

  // product stage, masked taps contribute zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      prod_win_q <= 1'b0;
    end else begin
      prod_vld_q <= tap_i.vld;
      prod_win_q <= tap_i.win;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= tap_i.use_tap ? line_i * coef_i : 32'sd0;
  end

  // accumulate into the selected window sum
  always_comb begin
    acc0_d = acc0_q;
    acc1_d = acc1_q;
    if (clr_i) begin
      acc0_d = '0;
      acc1_d = '0;
    end else if (prod_vld_q) begin
      if (prod_win_q) begin
        acc1_d = acc1_q + prod_q;
      end else begin
        acc0_d = acc0_q + prod_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc0_q <= '0;
      acc1_q <= '0;
    end else begin
      acc0_q <= acc0_d;
      acc1_q <= acc1_d;
    end
  end

  assign acc0_o = acc0_q;
  assign acc1_o = acc1_q;

endmodule

`default_nettype wire
